### hdl/opqs_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// opqs_pkg: shared types for the outline point to quadratic segment unit
// Point, job and segment records and the widths they follow from.
// ----------------------------------------------------------------------------
package opqs_pkg;

    localparam int COORD_BITS  = 16;
    localparam int OUT_BITS    = COORD_BITS + 1;
    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);
    localparam int TDATA_IN    = 2 * COORD_BITS;
    localparam int TDATA_OUT   = ((6 * OUT_BITS + 7) / 8) * 8;

    typedef struct packed {
        logic signed [COORD_BITS-1:0] x;
        logic signed [COORD_BITS-1:0] y;
        logic                         on;
    } t_point;

    // slot 0: segment of the previous point; slot 1: segment of the closing
    // point; slot 2: wrap segment of a leading off-curve point
    typedef struct packed {
        t_point     pbp;
        t_point     prv;
        t_point     cur;
        t_point     fst;
        t_point     snd;
        logic       single;
        logic [2:0] slot_valid;
    } t_job;

    typedef struct packed {
        logic signed [OUT_BITS-1:0] sx;
        logic signed [OUT_BITS-1:0] sy;
        logic signed [OUT_BITS-1:0] cx;
        logic signed [OUT_BITS-1:0] cy;
        logic signed [OUT_BITS-1:0] ex;
        logic signed [OUT_BITS-1:0] ey;
    } t_segment;

endpackage
`default_nettype wire

### hdl/opqs_front.sv
`default_nettype none
// ----------------------------------------------------------------------------
// opqs_front: point intake and classification
// Tracks the open contour and turns each point that yields a segment into a job for the back end.
// ----------------------------------------------------------------------------
module opqs_front
    import opqs_pkg::*;
(
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    input  wire logic   i_valid,
    output logic        o_ready,
    input  wire t_point i_point,
    input  wire logic   i_last,
    input  wire logic   i_full,
    output logic        o_push,
    output t_job        o_job
);

    logic [1:0] r_count, n_count;
    t_point     r_fst, r_snd, r_prv, r_pbp;
    logic       accept, is0, is1, ge2, prev_seg;
    logic [2:0] slots;

    assign o_ready  = !i_full;
    assign accept   = i_valid && o_ready;
    assign is0      = (r_count == 2'd0);
    assign is1      = (r_count == 2'd1);
    assign ge2      = r_count[1];
    assign prev_seg = ge2 || (is1 && r_prv.on);

    always_comb begin
        slots[0] = prev_seg && (!r_prv.on || i_point.on);
        slots[1] = i_last && (is0 || !i_point.on || r_fst.on);
        slots[2] = i_last && !is0 && !r_fst.on;
    end

    always_comb begin
        o_job.pbp        = r_pbp;
        o_job.prv        = r_prv;
        o_job.cur        = i_point;
        o_job.fst        = r_fst;
        o_job.snd        = is1 ? i_point : r_snd;
        o_job.single     = is0;
        o_job.slot_valid = slots;
    end

    assign o_push = accept && (slots != 3'b000);

    always_comb begin
        n_count = r_count;
        if (accept) begin
            if (i_last) begin
                n_count = 2'd0;
            end else if (!ge2) begin
                n_count = r_count + 2'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= 2'd0;
        end else begin
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept && !i_last) begin
            if (is0) begin
                r_fst <= i_point;
            end
            if (is1) begin
                r_snd <= i_point;
            end
            r_pbp <= r_prv;
            r_prv <= i_point;
        end
    end

endmodule
`default_nettype wire

### hdl/opqs_queue.sv
`default_nettype none
// ----------------------------------------------------------------------------
// opqs_queue: job queue between front and back end
// Small register queue; the head is read directly by the back end.
// ----------------------------------------------------------------------------
module opqs_queue
    import opqs_pkg::*;
(
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_push,
    input  wire t_job i_job,
    input  wire logic i_pop,
    output logic      o_full,
    output logic      o_empty,
    output t_job      o_head
);

    t_job              r_mem [QUEUE_DEPTH];
    logic [QUEUE_AW-1:0] r_wr, r_rd;
    logic [QUEUE_AW:0]   r_count, n_count;

    assign o_full  = (r_count == (QUEUE_AW + 1)'(QUEUE_DEPTH));
    assign o_empty = (r_count == '0);
    assign o_head  = r_mem[r_rd];

    always_comb begin
        n_count = r_count;
        if (i_push && !i_pop) begin
            n_count = r_count + (QUEUE_AW + 1)'(1);
        end else if (i_pop && !i_push) begin
            n_count = r_count - (QUEUE_AW + 1)'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            r_count <= n_count;
            if (i_push) begin
                r_wr <= r_wr + QUEUE_AW'(1);
            end
            if (i_pop) begin
                r_rd <= r_rd + QUEUE_AW'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_job;
        end
    end

endmodule
`default_nettype wire

### hdl/opqs_back.sv
`default_nettype none
// ----------------------------------------------------------------------------
// opqs_back: segment generation
// Emits the segments of the head job one per cycle while the receiver takes them into an output register.
// ----------------------------------------------------------------------------
module opqs_back
    import opqs_pkg::*;
(
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_empty,
    input  wire t_job i_head,
    output logic      o_pop,
    output logic      o_valid,
    input  wire logic i_ready,
    output t_segment  o_seg,
    output logic      o_last
);

    function automatic logic signed [OUT_BITS-1:0] widen(
        input logic signed [COORD_BITS-1:0] v
    );
        return {v[COORD_BITS-1], v};
    endfunction

    function automatic logic signed [OUT_BITS-1:0] twice(
        input logic signed [COORD_BITS-1:0] v
    );
        return {v, 1'b0};
    endfunction

    function automatic t_segment seg_calc(input t_point p, input t_point c,
                                          input t_point n);
        t_segment s;
        if (c.on) begin
            s.sx = twice(c.x);
            s.sy = twice(c.y);
            s.cx = widen(c.x) + widen(n.x);
            s.cy = widen(c.y) + widen(n.y);
            s.ex = twice(n.x);
            s.ey = twice(n.y);
        end else begin
            s.sx = p.on ? twice(p.x) : widen(p.x) + widen(c.x);
            s.sy = p.on ? twice(p.y) : widen(p.y) + widen(c.y);
            s.cx = twice(c.x);
            s.cy = twice(c.y);
            s.ex = n.on ? twice(n.x) : widen(n.x) + widen(c.x);
            s.ey = n.on ? twice(n.y) : widen(n.y) + widen(c.y);
        end
        return s;
    endfunction

    logic [2:0] r_done, n_done, pend, pick, rest;
    logic       r_valid, load;
    t_segment   r_seg, seg;
    logic       r_last;
    t_point     sp, sc, sn;

    assign pend = i_head.slot_valid & ~r_done;

    always_comb begin
        if (pend[0]) begin
            pick = 3'b001;
        end else if (pend[1]) begin
            pick = 3'b010;
        end else begin
            pick = 3'b100;
        end
    end

    assign rest  = pend & ~pick;
    assign load  = !i_empty && (!r_valid || i_ready);
    assign o_pop = load && (rest == 3'b000);

    always_comb begin
        case (pick)
            3'b001: begin
                sp = i_head.pbp;
                sc = i_head.prv;
                sn = i_head.cur;
            end
            3'b010: begin
                sp = i_head.single ? i_head.cur : i_head.prv;
                sc = i_head.cur;
                sn = i_head.single ? i_head.cur : i_head.fst;
            end
            default: begin
                sp = i_head.cur;
                sc = i_head.fst;
                sn = i_head.snd;
            end
        endcase
    end

    assign seg = seg_calc(sp, sc, sn);

    always_comb begin
        n_done = r_done;
        if (load) begin
            n_done = (rest == 3'b000) ? 3'b000 : (r_done | pick);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_done  <= 3'b000;
        end else begin
            r_done <= n_done;
            if (load) begin
                r_valid <= 1'b1;
            end else if (i_ready) begin
                r_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_seg  <= seg;
            r_last <= (rest == 3'b000);
        end
    end

    assign o_valid = r_valid;
    assign o_seg   = r_seg;
    assign o_last  = r_last;

`ifndef SYNTHESIS
    a_head_has_work: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_empty |-> (pend != 3'b000))
        else $error("queue head has no segment left");

    a_done_within_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_empty |-> ((r_done & ~i_head.slot_valid) == 3'b000))
        else $error("emitted slot mask exceeds the head's slots");

    a_done_clear_on_pop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_pop |=> (r_done == 3'b000))
        else $error("slot mask kept after pop");

    a_stall_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_valid && !i_ready) |=> (r_valid && $stable(r_seg) && $stable(r_last)))
        else $error("output register changed under stall");
`endif

endmodule
`default_nettype wire

### hdl/outline_points_to_quadratic_segments_unit.sv
`default_nettype none
// ----------------------------------------------------------------------------
// outline_points_to_quadratic_segments_unit: outline points to quadratic
// Bezier segments
// Input stream: one outline point per item; tdata carries px then py, tuser
// the on-curve flag and tlast the contour-end flag. Output stream: one
// segment per item; tdata carries start, control and end coordinates in half
// font units, tlast marks the final segment caused by one input point.
// A point is taken in the cycle it is offered while the four-entry job queue
// has room, so the block sustains one point per cycle. The first segment of
// a point passes through the job queue and the output register to the
// output. The back end emits one segment per cycle while the receiver takes
// them; a contour end yields up to three segments and so holds the back end
// longer, which the queue absorbs. Points that yield no segment never reach
// the queue. A leading off-curve point's segment comes last in its contour.
// Reset (synchronous, active low) empties the queue and the output register
// and opens a fresh contour. When the receiver stalls, the output register
// holds its segment, the queue fills, and the input then stalls.
// ----------------------------------------------------------------------------
module outline_points_to_quadratic_segments_unit
    import opqs_pkg::*;
(
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_s_axis_tvalid,
    output logic                      o_s_axis_tready,
    input  wire logic [TDATA_IN-1:0]  i_s_axis_tdata,   // px, py
    input  wire logic                 i_s_axis_tuser,   // on_curve
    input  wire logic                 i_s_axis_tlast,   // contour_end
    output logic                      o_m_axis_tvalid,
    input  wire logic                 i_m_axis_tready,
    output logic [TDATA_OUT-1:0]      o_m_axis_tdata,   // start_x, start_y, ctrl_x,
                                                        // ctrl_y, end_x, end_y
    output logic                      o_m_axis_tlast    // last_of_run
);

    t_point   in_point;
    t_job     push_job, head_job;
    logic     push, pop, full, empty;
    t_segment seg;

    always_comb begin
        in_point.x  = i_s_axis_tdata[COORD_BITS-1:0];
        in_point.y  = i_s_axis_tdata[2*COORD_BITS-1:COORD_BITS];
        in_point.on = i_s_axis_tuser;
    end

    opqs_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_s_axis_tvalid),
        .o_ready (o_s_axis_tready),
        .i_point (in_point),
        .i_last  (i_s_axis_tlast),
        .i_full  (full),
        .o_push  (push),
        .o_job   (push_job)
    );

    opqs_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_job   (push_job),
        .i_pop   (pop),
        .o_full  (full),
        .o_empty (empty),
        .o_head  (head_job)
    );

    opqs_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_empty (empty),
        .i_head  (head_job),
        .o_pop   (pop),
        .o_valid (o_m_axis_tvalid),
        .i_ready (i_m_axis_tready),
        .o_seg   (seg),
        .o_last  (o_m_axis_tlast)
    );

    assign o_m_axis_tdata = {(TDATA_OUT - 6 * OUT_BITS)'(0),
                             seg.ey, seg.ex, seg.cy, seg.cx, seg.sy, seg.sx};

endmodule
`default_nettype wire

### tb/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top: outline point to quadratic segment unit
// Streams outline points into the unit and checks every segment against a
// predictor held in the bench, in order and field by field. A directed set
// covers single, two-point, all off-curve and leading off-curve contours and
// the coordinate extremes. Random contours of mixed length and curve flags
// follow, under phases of sender idling and receiver stalling, plus one long
// receiver hold-off that backs the unit up to its input.
// ----------------------------------------------------------------------------
module tb_top
    import opqs_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    localparam int CYCLE_LIMIT = 400000;
    localparam int HOLD_CYCLES = 250;

    typedef struct {
        logic signed [COORD_BITS-1:0] x;
        logic signed [COORD_BITS-1:0] y;
        bit                           on;
        bit                           closes;
    } t_outline_point;

    typedef struct packed {
        logic [5:0][OUT_BITS-1:0] c;    // start_x, start_y, ctrl_x, ctrl_y, end_x, end_y
        logic                     last;
    } t_quad_segment;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n = 1'b0;
    logic                 i_s_axis_tvalid = 1'b0;
    logic                 o_s_axis_tready;
    logic [TDATA_IN-1:0]  i_s_axis_tdata = '0;      // px, py
    logic                 i_s_axis_tuser = 1'b0;    // on_curve
    logic                 i_s_axis_tlast = 1'b0;    // contour_end
    logic                 o_m_axis_tvalid;
    logic                 i_m_axis_tready = 1'b0;
    logic [TDATA_OUT-1:0] o_m_axis_tdata;           // start_x, start_y, ctrl_x,
                                                    // ctrl_y, end_x, end_y
    logic                 o_m_axis_tlast;           // last_of_run

    t_outline_point pending_points [$];
    t_quad_segment  segments_due [$];

    int  points_queued = 0;
    int  points_taken = 0;
    int  cycle_count = 0;
    int  errors = 0;
    int  send_idle_pct = 0;
    int  recv_stall_pct = 0;
    bit  point_taken = 1'b0;
    bit  hold_req = 1'b0;
    bit  hold_seen = 1'b0;
    int  hold_left = 0;

    string field_name [6] = '{"start_x", "start_y", "ctrl_x", "ctrl_y", "end_x", "end_y"};

    // contour state of the predictor
    t_point     head_pt = '0;
    t_point     second_pt = '0;
    t_point     last_pt = '0;
    t_point     last2_pt = '0;
    logic [1:0] contour_len = '0;

    outline_points_to_quadratic_segments_unit dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .i_s_axis_tuser  (i_s_axis_tuser),
        .i_s_axis_tlast  (i_s_axis_tlast),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .o_m_axis_tlast  (o_m_axis_tlast)
    );

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    function automatic logic [OUT_BITS-1:0] twice(input logic signed [COORD_BITS-1:0] v);
        return {v, 1'b0};
    endfunction

    function automatic logic [OUT_BITS-1:0] pair_sum(input logic signed [COORD_BITS-1:0] a,
                                                     input logic signed [COORD_BITS-1:0] b);
        logic signed [OUT_BITS-1:0] ea;
        logic signed [OUT_BITS-1:0] eb;
        ea = OUT_BITS'(a);
        eb = OUT_BITS'(b);
        return ea + eb;
    endfunction

    function automatic bit shape_segment(input t_point prv, input t_point cur, input t_point nxt,
                                         output t_quad_segment seg);
        seg = '0;
        if (cur.on) begin
            if (!nxt.on) return 1'b0;
            seg.c[0] = twice(cur.x);
            seg.c[1] = twice(cur.y);
            seg.c[2] = pair_sum(cur.x, nxt.x);
            seg.c[3] = pair_sum(cur.y, nxt.y);
            seg.c[4] = twice(nxt.x);
            seg.c[5] = twice(nxt.y);
            return 1'b1;
        end
        seg.c[0] = prv.on ? twice(prv.x) : pair_sum(prv.x, cur.x);
        seg.c[1] = prv.on ? twice(prv.y) : pair_sum(prv.y, cur.y);
        seg.c[2] = twice(cur.x);
        seg.c[3] = twice(cur.y);
        seg.c[4] = nxt.on ? twice(nxt.x) : pair_sum(nxt.x, cur.x);
        seg.c[5] = nxt.on ? twice(nxt.y) : pair_sum(nxt.y, cur.y);
        return 1'b1;
    endfunction

    task automatic trace_outline_point(input t_point cur, input bit closes);
        t_quad_segment run_segs [$];
        t_quad_segment s;
        int            idx;
        if (contour_len >= 2 || (contour_len == 1 && last_pt.on)) begin
            if (shape_segment(last2_pt, last_pt, cur, s)) run_segs = {run_segs, s};
        end
        if (closes) begin
            if (contour_len == 0) begin
                if (shape_segment(cur, cur, cur, s)) run_segs = {run_segs, s};
            end else begin
                if (shape_segment(last_pt, cur, head_pt, s)) run_segs = {run_segs, s};
                if (!head_pt.on) begin
                    if (shape_segment(cur, head_pt, (contour_len == 1) ? cur : second_pt, s))
                        run_segs = {run_segs, s};
                end
            end
            contour_len = '0;
        end else begin
            if (contour_len == 0) head_pt = cur;
            else if (contour_len == 1) second_pt = cur;
            last2_pt = last_pt;
            last_pt = cur;
            if (contour_len != 2) contour_len = contour_len + 2'd1;
        end
        if (run_segs.size() > 0) begin
            idx = run_segs.size() - 1;
            run_segs[idx].last = 1'b1;
            segments_due = {segments_due, run_segs};
        end
    endtask

    task automatic add_point(input int x, input int y, input bit on, input bit closes);
        t_outline_point p;
        p.x = COORD_BITS'(x);
        p.y = COORD_BITS'(y);
        p.on = on;
        p.closes = closes;
        pending_points = {pending_points, p};
        points_queued++;
    endtask

    function automatic logic [COORD_BITS-1:0] pick_coord();
        case ($urandom_range(0, 15))
            0: return 16'h8000;
            1: return 16'h7fff;
            2: return 16'h0000;
            3: return 16'hffff;
            default: return COORD_BITS'($urandom);
        endcase
    endfunction

    task automatic fill_contours(input int budget);
        int len;
        while (budget > 0) begin
            len = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 40) : $urandom_range(1, 6);
            if (len > budget) len = budget;
            for (int i = 0; i < len; i++) begin
                add_point(int'($signed(pick_coord())), int'($signed(pick_coord())),
                          1'($urandom_range(0, 1)), i == len - 1);
            end
            budget -= len;
        end
    endtask

    task automatic drain_points();
        while (points_taken != points_queued) @(posedge i_clk);
    endtask

    // sender: hold an item until taken, then offer the next or idle
    always @(negedge i_clk) begin
        t_outline_point      p;
        logic                v;
        logic [TDATA_IN-1:0] d;
        logic                u;
        logic                l;
        v = i_s_axis_tvalid;
        d = i_s_axis_tdata;
        u = i_s_axis_tuser;
        l = i_s_axis_tlast;
        if (!i_rst_n) begin
            v = 1'b0;
        end else if (!i_s_axis_tvalid || point_taken) begin
            v = 1'b0;
            if (pending_points.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
                p = pending_points.pop_front();
                v = 1'b1;
                d = {p.y, p.x};
                u = p.on;
                l = p.closes;
            end
        end
        i_s_axis_tvalid <= v;
        i_s_axis_tdata <= d;
        i_s_axis_tuser <= u;
        i_s_axis_tlast <= l;
    end

    // receiver: random stalls, plus one long hold-off on request
    always @(negedge i_clk) begin
        if (hold_req != hold_seen) begin
            hold_seen <= hold_req;
            hold_left <= HOLD_CYCLES;
            i_m_axis_tready <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left <= hold_left - 1;
            i_m_axis_tready <= 1'b0;
        end else begin
            i_m_axis_tready <= i_rst_n && ($urandom_range(0, 99) >= recv_stall_pct);
        end
    end

    // monitor: predict on each taken point, check each delivered segment
    always @(posedge i_clk) begin
        t_quad_segment exp_seg;
        t_point        cur;
        logic [OUT_BITS-1:0] got;
        cycle_count++;
        point_taken <= i_rst_n && i_s_axis_tvalid && o_s_axis_tready;
        if (i_rst_n && i_s_axis_tvalid && o_s_axis_tready) begin
            cur.x = i_s_axis_tdata[COORD_BITS-1:0];
            cur.y = i_s_axis_tdata[2*COORD_BITS-1:COORD_BITS];
            cur.on = i_s_axis_tuser;
            trace_outline_point(cur, i_s_axis_tlast);
            points_taken++;
        end
        if (i_rst_n && o_m_axis_tvalid && i_m_axis_tready) begin
            if (segments_due.size() == 0) begin
                errors++;
                $error("segment delivered with none due");
            end else begin
                exp_seg = segments_due.pop_front();
                for (int k = 0; k < 6; k++) begin
                    got = o_m_axis_tdata[k*OUT_BITS +: OUT_BITS];
                    if (got !== exp_seg.c[k]) begin
                        errors++;
                        $error("%s: expected %0d, got %0d", field_name[k],
                               $signed(exp_seg.c[k]), $signed(got));
                    end
                end
                if (o_m_axis_tlast !== exp_seg.last) begin
                    errors++;
                    $error("last_of_run: expected %0d, got %0d", exp_seg.last,
                           o_m_axis_tlast);
                end
            end
        end
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("end of test: mismatches");
            $finish;
        end
    end

    initial begin
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // directed: extremes, short contours, implied midpoints, leading off-curve
        add_point(32767, 32767, 1, 1);
        add_point(-32768, -32768, 0, 1);
        add_point(-32768, 32767, 1, 0);
        add_point(32767, -32768, 1, 1);
        add_point(100, 200, 1, 0);
        add_point(-300, 400, 0, 1);
        add_point(5, 6, 0, 0);
        add_point(7, -8, 0, 1);
        add_point(10, 10, 0, 0);
        add_point(20, 0, 1, 0);
        add_point(30, 30, 0, 0);
        add_point(40, -5, 0, 0);
        add_point(50, 50, 1, 0);
        add_point(60, 60, 1, 1);
        add_point(32767, 32767, 0, 0);
        add_point(32767, -32768, 0, 0);
        add_point(-32768, -32768, 0, 0);
        add_point(-32768, 32767, 0, 1);
        add_point(0, 0, 1, 0);
        add_point(1, 1, 1, 0);
        add_point(-1, -1, 0, 1);
        fill_contours(90);
        drain_points();

        send_idle_pct = 83;
        fill_contours(90);
        drain_points();

        send_idle_pct = 0;
        recv_stall_pct = 83;
        fill_contours(90);
        drain_points();

        send_idle_pct = 18;
        recv_stall_pct = 18;
        fill_contours(90);
        drain_points();

        // back the unit up: receiver holds off while the sender keeps offering
        send_idle_pct = 0;
        recv_stall_pct = 0;
        hold_req = 1'b1;
        fill_contours(60);
        drain_points();

        fill_contours(30);
        drain_points();

        while (segments_due.size() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
        if (errors == 0 && segments_due.size() == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

endmodule
